// ===== rtl/sese_pkg.sv =====
// Package with shared types and constants for the subset enumerator.
package sese_pkg;

    localparam int MASK_W  = 32;
    localparam int SIZE_W  = 6;
    localparam int COUNT_W = 64;
    localparam int MAX_N   = 32;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COUNT,
        ST_RANK_INIT,
        ST_RANK,
        ST_RANK_ACC,
        ST_ROOM,
        ST_ROOM_CALC,
        ST_DECIDE,
        ST_NEXT_SIZE,
        ST_UNRANK_INIT,
        ST_UNRANK,
        ST_UNRANK_ACC,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic trim;
        logic count_step;
        logic rank_init;
        logic rank_step;
        logic room_sel;
        logic room_calc;
        logic take_within;
        logic take_block;
        logic set_end;
        logic next_size;
        logic unrank_init;
        logic unrank_step;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic count_done;
        logic walk_done;
        logic left_zero;
        logic fits;
        logic size_full;
        logic past_end;
    } status_t;

endpackage

// ===== rtl/sese_binom.sv =====
// Binomial coefficient ROM C(a,b) built from Pascal's triangle, with a registered read.
module sese_binom (
    input  logic        aclk,
    input  logic [6:0]  a,
    input  logic [6:0]  b,
    output logic [63:0] c
);
    logic [63:0] tab [0:sese_pkg::MAX_N][0:sese_pkg::MAX_N];
    logic [63:0] c_reg;

    initial begin
        for (int x = 0; x <= sese_pkg::MAX_N; x++) begin
            for (int y = 0; y <= sese_pkg::MAX_N; y++) begin
                if (y == 0) tab[x][y] = 64'd1;
                else if (y > x) tab[x][y] = 64'd0;
                else tab[x][y] = tab[x-1][y-1] + tab[x-1][y];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a > 7'(sese_pkg::MAX_N) || b > 7'(sese_pkg::MAX_N)) c_reg <= '0;
        else c_reg <= tab[a[5:0]][b[5:0]];
    end

    assign c = c_reg;
endmodule

// ===== rtl/sese_datapath.sv =====
// Datapath of the subset enumerator: mask, size, rank and step counters.
module sese_datapath (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [5:0]                 n,
    input  logic [31:0]                start_mask,
    input  logic [63:0]                amount,
    input  sese_pkg::cmd_t             cmd,
    output sese_pkg::status_t          status,
    output logic [31:0]                mask_out,
    output logic [5:0]                 size_out,
    output logic                       end_out,
    output logic [63:0]                steps_out
);
    logic [31:0] mask_reg;
    logic [5:0]  size_reg;
    logic        end_reg;
    logic [63:0] left_reg, steps_reg, rank_reg, room_reg;
    logic [5:0]  pos_reg, taken_reg;
    logic [31:0] newm_reg;
    logic [6:0]  ba, bb;
    logic [63:0] bc;
    logic [31:0] nmask;

    sese_binom u_binom (.aclk(aclk), .a(ba), .b(bb), .c(bc));

    assign nmask = (n >= 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);

    always_comb begin
        ba = {1'b0, n} - {1'b0, pos_reg} - 7'd1;
        bb = {1'b0, size_reg} - {1'b0, taken_reg} - 7'd1;
        if (cmd.room_sel) begin
            ba = {1'b0, n};
            bb = {1'b0, size_reg};
        end
    end

    assign status.count_done = (pos_reg == 6'd32) || (pos_reg == n);
    assign status.walk_done  = (pos_reg == n) || (taken_reg == size_reg);
    assign status.left_zero  = (left_reg == 64'd0);
    assign status.fits       = (left_reg <= room_reg);
    assign status.size_full  = (size_reg >= n);
    assign status.past_end   = end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
            size_reg <= '0;
            end_reg  <= 1'b0;
        end else begin
            if (cmd.load) begin
                mask_reg  <= start_mask & nmask;
                end_reg   <= 1'b0;
                steps_reg <= '0;
                size_reg  <= '0;
                pos_reg   <= '0;
                left_reg  <= '0;
            end
            if (cmd.trim) begin
                mask_reg  <= mask_reg & nmask;
                size_reg  <= '0;
                pos_reg   <= '0;
                steps_reg <= '0;
                left_reg  <= amount;
            end
            if (cmd.count_step) begin
                size_reg <= size_reg + {5'd0, mask_reg[pos_reg[4:0]]};
                pos_reg  <= pos_reg + 6'd1;
            end
            if (cmd.rank_init || cmd.unrank_init) begin
                pos_reg   <= '0;
                taken_reg <= '0;
                newm_reg  <= '0;
            end
            if (cmd.rank_init) rank_reg <= '0;
            if (cmd.rank_step) begin
                if (mask_reg[pos_reg[4:0]]) taken_reg <= taken_reg + 6'd1;
                else rank_reg <= rank_reg + bc;
                pos_reg <= pos_reg + 6'd1;
            end
            if (cmd.room_calc) room_reg <= bc - 64'd1 - rank_reg;
            if (cmd.take_within) begin
                steps_reg <= steps_reg + left_reg;
                rank_reg  <= rank_reg + left_reg;
                left_reg  <= '0;
            end
            if (cmd.take_block) begin
                steps_reg <= steps_reg + room_reg + 64'd1;
                left_reg  <= left_reg - room_reg - 64'd1;
            end
            if (cmd.set_end) begin
                end_reg  <= 1'b1;
                mask_reg <= '0;
                size_reg <= '0;
            end
            if (cmd.next_size) begin
                size_reg <= size_reg + 6'd1;
                mask_reg <= (size_reg >= 6'd31) ? 32'hFFFF_FFFF
                          : ((32'd1 << (size_reg + 6'd1)) - 32'd1);
            end
            if (cmd.unrank_step) begin
                if (rank_reg < bc) begin
                    newm_reg[pos_reg[4:0]] <= 1'b1;
                    taken_reg <= taken_reg + 6'd1;
                end else begin
                    rank_reg <= rank_reg - bc;
                end
                pos_reg <= pos_reg + 6'd1;
            end
            if (cmd.commit) mask_reg <= newm_reg;
        end
    end

    assign mask_out  = end_reg ? '0 : mask_reg;
    assign size_out  = end_reg ? '0 : size_reg;
    assign end_out   = end_reg;
    assign steps_out = steps_reg;
endmodule

// ===== rtl/sese_ctrl.sv =====
// Controller state machine of the subset enumerator.
module sese_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic               s_op,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  sese_pkg::status_t  status,
    output sese_pkg::cmd_t     cmd
);
    sese_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= sese_pkg::ST_IDLE;
        else state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        unique case (state_reg)
            sese_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_op == sese_pkg::OP_LOAD) cmd.load = 1'b1;
                    else cmd.trim = 1'b1;
                    state_next = sese_pkg::ST_COUNT;
                end
            end
            sese_pkg::ST_COUNT: begin
                if (status.count_done) begin
                    state_next = status.left_zero || status.past_end
                               ? sese_pkg::ST_OUT : sese_pkg::ST_RANK_INIT;
                end else begin
                    cmd.count_step = 1'b1;
                end
            end
            sese_pkg::ST_RANK_INIT: begin
                cmd.rank_init = 1'b1;
                state_next = sese_pkg::ST_RANK;
            end
            sese_pkg::ST_RANK: begin
                if (status.walk_done) state_next = sese_pkg::ST_ROOM;
                else state_next = sese_pkg::ST_RANK_ACC;
            end
            sese_pkg::ST_RANK_ACC: begin
                cmd.rank_step = 1'b1;
                state_next = sese_pkg::ST_RANK;
            end
            sese_pkg::ST_ROOM: begin
                cmd.room_sel = 1'b1;
                state_next = sese_pkg::ST_ROOM_CALC;
            end
            sese_pkg::ST_ROOM_CALC: begin
                cmd.room_calc = 1'b1;
                state_next = sese_pkg::ST_DECIDE;
            end
            sese_pkg::ST_DECIDE: begin
                if (status.fits) begin
                    cmd.take_within = 1'b1;
                    state_next = sese_pkg::ST_UNRANK_INIT;
                end else begin
                    cmd.take_block = 1'b1;
                    state_next = sese_pkg::ST_NEXT_SIZE;
                end
            end
            sese_pkg::ST_NEXT_SIZE: begin
                if (status.size_full) begin
                    cmd.set_end = 1'b1;
                    state_next = sese_pkg::ST_OUT;
                end else if (status.left_zero) begin
                    cmd.next_size = 1'b1;
                    state_next = sese_pkg::ST_OUT;
                end else begin
                    cmd.next_size = 1'b1;
                    state_next = sese_pkg::ST_RANK_INIT;
                end
            end
            sese_pkg::ST_UNRANK_INIT: begin
                cmd.unrank_init = 1'b1;
                state_next = sese_pkg::ST_UNRANK;
            end
            sese_pkg::ST_UNRANK: begin
                if (status.walk_done) begin
                    cmd.commit = 1'b1;
                    state_next = sese_pkg::ST_OUT;
                end else begin
                    state_next = sese_pkg::ST_UNRANK_ACC;
                end
            end
            sese_pkg::ST_UNRANK_ACC: begin
                cmd.unrank_step = 1'b1;
                state_next = sese_pkg::ST_UNRANK;
            end
            sese_pkg::ST_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) state_next = sese_pkg::ST_IDLE;
            end
            default: state_next = sese_pkg::ST_IDLE;
        endcase
    end
endmodule

// ===== rtl/subset_enumerator_skip_ahead.sv =====
// Top level of the subset enumerator with binomial skip-ahead.
// The block walks all subsets of {1..n}, size by size, each size in
// lexicographic order, and ends one step past the full set.
// The slave channel takes one transfer per command: a load of a start
// mask or an advance by a 64-bit amount. The master channel returns one
// transfer per command with the new mask, its size, the end flag and the
// number of steps actually taken.
// The set size n is written through cfg_wr_en and cfg_wr_data; the user
// must write it only while idle, as the block itself does not enforce it.
// A load, or an advance in the end state, counts the mask and returns the
// result. An advance counts the trimmed mask, steps through every size it
// passes, ranking the subset and skipping the rest of that size, and then
// unranks the final subset; each element of the rank and unrank walks passes
// through a check state and an accumulate state, since the binomial table
// read is registered. The next command is accepted in the cycle after the result transfers.
// The result is held until the receiver takes it; no new command is
// accepted meanwhile. After reset the subset is empty, not at end, n = 0.
module subset_enumerator_skip_ahead (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [5:0]   cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // start_mask[31:0], amount[95:32]
    input  logic         s_tuser,   // op
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata    // subset_mask, subset_size, at_end, steps_taken, pad
);
    logic [5:0] set_size_reg;
    logic [5:0] n;
    sese_pkg::cmd_t    cmd;
    sese_pkg::status_t status;
    logic [31:0] mask_out;
    logic [5:0]  size_out;
    logic        end_out;
    logic [63:0] steps_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) set_size_reg <= '0;
        else if (cfg_wr_en) set_size_reg <= cfg_wr_data;
    end

    assign n = (set_size_reg > 6'(sese_pkg::MAX_N)) ? 6'(sese_pkg::MAX_N) : set_size_reg;

    sese_ctrl u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_op(s_tuser),
        .m_tvalid, .m_tready, .status, .cmd
    );

    sese_datapath u_dp (
        .aclk, .aresetn, .n, .start_mask(s_tdata[31:0]), .amount(s_tdata[95:32]),
        .cmd, .status, .mask_out, .size_out, .end_out, .steps_out
    );

    assign m_tdata = {1'b0, steps_out, end_out, size_out, mask_out};

`ifndef SYNTHESIS
    a_end_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[38] |-> m_tdata[37:0] == 38'd0)
        else $error("end state with nonempty mask");
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input accepted while result pending");
    a_size_le_n: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[37:32] <= n)
        else $error("subset size exceeds n");
`endif
endmodule
